// ===== hw/rtl/pmm_pkg.sv =====
`timescale 1ns / 1ps

package pmm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BG_SKIP       = 2'd0;
    localparam logic [1:0] CFG_DISCARD_LEVEL = 2'd1;
    localparam logic [1:0] CFG_BG_WINDOW     = 2'd2;
    localparam logic [1:0] CFG_MOVE_WINDOW   = 2'd3;

    // q8 clamp: above 254.0 becomes 255.0
    localparam logic [15:0] CLAMP_LIMIT = 16'd65024;
    localparam logic [15:0] CLAMP_VALUE = 16'd65280;

    // mod lanes run over a 16 bit dividend
    localparam int MOD_STEPS = 16;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic acc_init;
        logic acc_step;
        logic div_load;
        logic div_step;
        logic finish;
        logic clear_step;
    } pmm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic acc_last;
        logic div_last;
    } pmm_status_t;

    // rounded gray of a 0/254 mask, bit 0 blue, bit 1 green, bit 2 red
    function automatic logic [7:0] gray_of_mask(input logic [2:0] mask);
        logic [7:0] g;
        begin
            case (mask)
                3'd0:    g = 8'd0;
                3'd1:    g = 8'd29;
                3'd2:    g = 8'd149;
                3'd3:    g = 8'd178;
                3'd4:    g = 8'd76;
                3'd5:    g = 8'd105;
                3'd6:    g = 8'd225;
                default: g = 8'd254;
            endcase
            return g;
        end
    endfunction

endpackage

// ===== hw/rtl/pmm_pix_if.sv =====
`timescale 1ns / 1ps

interface pmm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last_pixel;

    modport source (output valid, blue, green, red, last_pixel, input ready);
    modport sink (input valid, blue, green, red, last_pixel, output ready);
endinterface

// ===== hw/rtl/pmm_mask_if.sv =====
`timescale 1ns / 1ps

interface pmm_mask_if;
    logic       valid;
    logic       ready;
    logic       moved_blue;
    logic       moved_green;
    logic       moved_red;
    logic [7:0] gray_level;

    modport source (output valid, moved_blue, moved_green, moved_red, gray_level,
                    input ready);
    modport sink (input valid, moved_blue, moved_green, moved_red, gray_level,
                  output ready);
endinterface

// ===== hw/rtl/pmm_div_lane.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per step
module pmm_div_lane #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        trial  = {r_reg, q_reg[NUM_W-1]};
        if (load)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
        end
        else if (step)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DEN_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DEN_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quo = q_reg;
    assign rem = r_reg;

endmodule

// ===== hw/rtl/pmm_controller.sv =====
`timescale 1ns / 1ps

module pmm_controller
    import pmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  pmm_status_t status,
    output pmm_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_DIVLD = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.acc_init = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (status.acc_last)
                begin
                    state_next = S_DIVLD;
                end
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/pmm_datapath.sv =====
`timescale 1ns / 1ps

module pmm_datapath
    import pmm_pkg::*;
#(
    parameter int PIXELS     = 4096,
    parameter int BG_DEPTH   = 16,
    parameter int MOVE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        last_pixel,
    input  pmm_cmd_t    cmd,
    output pmm_status_t status,
    output logic        moved_blue,
    output logic        moved_green,
    output logic        moved_red,
    output logic [7:0]  gray_level
);

    localparam int PP_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int BI_W   = (BG_DEPTH > 1) ? $clog2(BG_DEPTH) : 1;
    localparam int BF_W   = $clog2(BG_DEPTH + 1);
    localparam int MI_W   = (MOVE_DEPTH > 1) ? $clog2(MOVE_DEPTH) : 1;
    localparam int MF_W   = $clog2(MOVE_DEPTH + 1);
    localparam int WS_MAX = MOVE_DEPTH * (MOVE_DEPTH + 1) / 2;
    localparam int REC_W  = $clog2(255 * WS_MAX + 1);
    localparam int NUM_W  = ((REC_W > 16) ? REC_W : 16) + 8;
    localparam int WS_W   = $clog2(WS_MAX + 1);
    localparam int BC_W   = $clog2(BG_DEPTH + 1);
    localparam int DEN_W  = (WS_W > BC_W) ? WS_W : BC_W;
    localparam int K_W    = $clog2(MOVE_DEPTH + 1);
    localparam int STEP_W = $clog2(NUM_W + 1);

    // configuration
    logic [7:0] bg_skip_reg, discard_reg;
    logic [4:0] bg_window_reg;
    logic [3:0] move_window_reg;

    // item and frame state
    logic [23:0]     pix_reg;
    logic            last_reg;
    logic [PP_W-1:0] pos_reg, pos_next;
    logic [15:0]     frame_reg, frame_next;
    logic [BF_W-1:0] bg_fill_reg, bg_fill_next;
    logic [BI_W-1:0] bg_head_reg, bg_head_next;
    logic [MF_W-1:0] mv_fill_reg, mv_fill_next;
    logic [MI_W-1:0] mv_head_reg, mv_head_next;
    logic [PP_W-1:0] clr_reg;
    logic [STEP_W-1:0] step_reg;
    logic [K_W-1:0]  k_reg;
    logic [MI_W-1:0] idx_reg, idx_next;
    logic [REC_W-1:0] rec_reg [3];
    logic [REC_W-1:0] rec_next [3];
    logic            mb_reg, mg_reg, mr_reg;
    logic [7:0]      gray_reg;

    // per pixel memories, one wide word per position
    logic [47:0]              sum_mem [PIXELS];
    logic [BG_DEPTH*24-1:0]   bgh_mem [PIXELS];
    logic [MOVE_DEPTH*24-1:0] mvh_mem [PIXELS];
    logic [47:0]              sum_rd_reg;
    logic [BG_DEPTH*24-1:0]   bgh_rd_reg;
    logic [MOVE_DEPTH*24-1:0] mvh_rd_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_skip_reg     <= 8'd1;
            discard_reg     <= 8'd30;
            bg_window_reg   <= 5'd16;
            move_window_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BG_SKIP:       bg_skip_reg     <= cfg_data;
                CFG_DISCARD_LEVEL: discard_reg     <= cfg_data;
                CFG_BG_WINDOW:     bg_window_reg   <= cfg_data[4:0];
                CFG_MOVE_WINDOW:   move_window_reg <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // effective skip and windows
    logic [7:0] skip8, bw8, mw8;
    always_comb
    begin
        skip8 = (bg_skip_reg == 8'd0) ? 8'd1 : bg_skip_reg;
        if (bg_window_reg == 5'd0)
            bw8 = 8'd1;
        else if ({3'b0, bg_window_reg} > 8'(BG_DEPTH))
            bw8 = 8'(BG_DEPTH);
        else
            bw8 = {3'b0, bg_window_reg};
        if (move_window_reg == 4'd0)
            mw8 = 8'd1;
        else if ({4'b0, move_window_reg} > 8'(MOVE_DEPTH))
            mw8 = 8'(MOVE_DEPTH);
        else
            mw8 = {4'b0, move_window_reg};
    end

    // remainders: frame count mod skip, heads mod window
    logic [7:0] skip_rem, bh8, mh8;
    pmm_div_lane #(.NUM_W(MOD_STEPS), .DEN_W(8)) u_mod_skip (
        .clk(clk), .load(cmd.load), .step(cmd.mod_step),
        .num(frame_reg), .den(skip8), .quo(), .rem(skip_rem)
    );
    pmm_div_lane #(.NUM_W(MOD_STEPS), .DEN_W(8)) u_mod_bh (
        .clk(clk), .load(cmd.load), .step(cmd.mod_step),
        .num(16'(bg_head_reg)), .den(bw8), .quo(), .rem(bh8)
    );
    pmm_div_lane #(.NUM_W(MOD_STEPS), .DEN_W(8)) u_mod_mh (
        .clk(clk), .load(cmd.load), .step(cmd.mod_step),
        .num(16'(mv_head_reg)), .den(mw8), .quo(), .rem(mh8)
    );

    // window bookkeeping
    logic       sampled, bg_full, mv_full;
    logic [7:0] bg_fill8, mv_fill8, bg_slot8, mv_slot8, bg_cnt8, n8, start8;
    logic [7:0] bh_inc8, mh_inc8;
    logic [8:0] bh_plus, mh_plus;
    logic [15:0] ws_prod;
    always_comb
    begin
        sampled  = (skip_rem == 8'd0);
        bg_fill8 = 8'(bg_fill_reg);
        mv_fill8 = 8'(mv_fill_reg);
        bg_full  = (bg_fill8 >= bw8);
        mv_full  = (mv_fill8 >= mw8);
        bh_plus  = 9'(bh8) + 9'(bg_fill8);
        mh_plus  = 9'(mh8) + 9'(mv_fill8);
        bh_inc8  = (8'(bh8 + 8'd1) == bw8) ? 8'd0 : 8'(bh8 + 8'd1);
        mh_inc8  = (8'(mh8 + 8'd1) == mw8) ? 8'd0 : 8'(mh8 + 8'd1);
        if (bg_full)
            bg_slot8 = bh8;
        else if (bh_plus >= 9'(bw8))
            bg_slot8 = 8'(bh_plus - 9'(bw8));
        else
            bg_slot8 = bh_plus[7:0];
        if (mv_full)
            mv_slot8 = mh8;
        else if (mh_plus >= 9'(mw8))
            mv_slot8 = 8'(mh_plus - 9'(mw8));
        else
            mv_slot8 = mh_plus[7:0];
        if (bg_full)
            bg_cnt8 = bw8;
        else if (sampled)
            bg_cnt8 = 8'(bg_fill8 + 8'd1);
        else
            bg_cnt8 = bg_fill8;
        n8      = mv_full ? mw8 : 8'(mv_fill8 + 8'd1);
        start8  = mv_full ? mh_inc8 : mh8;
        ws_prod = 16'(n8) * 16'(n8 + 8'd1);
    end

    // ring entries of the fetched words
    logic [23:0] bg_ent [BG_DEPTH];
    logic [23:0] mv_ent [MOVE_DEPTH];
    always_comb
    begin
        for (int j = 0; j < BG_DEPTH; j++)
            bg_ent[j] = bgh_rd_reg[j*24 +: 24];
        for (int j = 0; j < MOVE_DEPTH; j++)
            mv_ent[j] = mvh_rd_reg[j*24 +: 24];
    end

    // background sum update
    logic [23:0] bg_old;
    logic [15:0] sum_old [3];
    logic [15:0] sum_new [3];
    logic [15:0] sum_eff [3];
    always_comb
    begin
        bg_old = bg_full ? bg_ent[bg_slot8[BI_W-1:0]] : 24'd0;
        for (int c = 0; c < 3; c++)
        begin
            sum_old[c] = sum_rd_reg[c*16 +: 16];
            sum_new[c] = 16'(sum_old[c] + {8'd0, pix_reg[c*8 +: 8]}
                             - {8'd0, bg_old[c*8 +: 8]});
            sum_eff[c] = sampled ? sum_new[c] : sum_old[c];
        end
    end

    // weighted recent sum, one frame per step
    logic [23:0]    acc_ent;
    logic [K_W:0]   weight;
    always_comb
    begin
        acc_ent  = (idx_reg == mv_slot8[MI_W-1:0]) ? pix_reg : mv_ent[idx_reg];
        weight   = (K_W + 1)'(k_reg) + 1'b1;
        idx_next = (8'(idx_reg) + 8'd1 == mw8) ? '0 : MI_W'(idx_reg + 1'b1);
        for (int c = 0; c < 3; c++)
            rec_next[c] = REC_W'(rec_reg[c] + REC_W'(acc_ent[c*8 +: 8] * weight));
    end

    // quotient lanes: 0..2 recent, 3..5 background
    logic [NUM_W-1:0] q [6];
    logic [NUM_W-1:0] qc [6];
    logic [DEN_W-1:0] ws_den, bg_den;
    assign ws_den = DEN_W'(ws_prod >> 1);
    assign bg_den = DEN_W'(bg_cnt8);

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        pmm_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_rec (
            .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
            .num(NUM_W'({rec_reg[c], 8'd0})), .den(ws_den), .quo(q[c]), .rem()
        );
        pmm_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_bg (
            .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
            .num(NUM_W'({sum_eff[c], 8'd0})), .den(bg_den), .quo(q[c+3]), .rem()
        );
    end

    // compare, mask and gray
    logic [NUM_W-1:0] diff [3];
    logic [2:0]       moved;
    always_comb
    begin
        for (int i = 0; i < 6; i++)
            qc[i] = (q[i] > NUM_W'(CLAMP_LIMIT)) ? NUM_W'(CLAMP_VALUE) : q[i];
        for (int c = 0; c < 3; c++)
        begin
            diff[c]  = (qc[c] > qc[c+3]) ? (qc[c] - qc[c+3]) : (qc[c+3] - qc[c]);
            moved[c] = (bg_cnt8 != 8'd0) && (diff[c] != '0)
                       && (diff[c] >= NUM_W'({discard_reg, 8'd0}));
        end
    end

    // new ring words
    logic [BG_DEPTH*24-1:0]   bgh_wr;
    logic [MOVE_DEPTH*24-1:0] mvh_wr;
    always_comb
    begin
        for (int j = 0; j < BG_DEPTH; j++)
            bgh_wr[j*24 +: 24] = (BI_W'(j) == bg_slot8[BI_W-1:0]) ? pix_reg : bg_ent[j];
        for (int j = 0; j < MOVE_DEPTH; j++)
            mvh_wr[j*24 +: 24] = (MI_W'(j) == mv_slot8[MI_W-1:0]) ? pix_reg : mv_ent[j];
    end

    // end of item pointer updates
    always_comb
    begin
        pos_next     = pos_reg;
        frame_next   = frame_reg;
        bg_fill_next = bg_fill_reg;
        bg_head_next = bg_head_reg;
        mv_fill_next = mv_fill_reg;
        mv_head_next = mv_head_reg;
        if (last_reg)
        begin
            pos_next   = '0;
            frame_next = 16'(frame_reg + 16'd1);
            if (sampled)
            begin
                if (bg_full)
                begin
                    bg_head_next = bh_inc8[BI_W-1:0];
                    bg_fill_next = bw8[BF_W-1:0];
                end
                else
                begin
                    bg_head_next = bh8[BI_W-1:0];
                    bg_fill_next = BF_W'(bg_fill_reg + 1'b1);
                end
            end
            if (mv_full)
            begin
                mv_head_next = mh_inc8[MI_W-1:0];
                mv_fill_next = mw8[MF_W-1:0];
            end
            else
            begin
                mv_head_next = mh8[MI_W-1:0];
                mv_fill_next = MF_W'(mv_fill_reg + 1'b1);
            end
        end
        else if (32'(pos_reg) == PIXELS - 1)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = PP_W'(pos_reg + 1'b1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            frame_reg   <= '0;
            bg_fill_reg <= '0;
            bg_head_reg <= '0;
            mv_fill_reg <= '0;
            mv_head_reg <= '0;
            clr_reg     <= '0;
            step_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_reg <= PP_W'(clr_reg + 1'b1);
            if (cmd.load || cmd.div_load)
                step_reg <= '0;
            else if (cmd.mod_step || cmd.div_step)
                step_reg <= STEP_W'(step_reg + 1'b1);
            if (cmd.acc_init)
                k_reg <= '0;
            else if (cmd.acc_step)
                k_reg <= K_W'(k_reg + 1'b1);
            if (cmd.finish)
            begin
                pos_reg     <= pos_next;
                frame_reg   <= frame_next;
                bg_fill_reg <= bg_fill_next;
                bg_head_reg <= bg_head_next;
                mv_fill_reg <= mv_fill_next;
                mv_head_reg <= mv_head_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg  <= {red, green, blue};
            last_reg <= last_pixel;
        end
        if (cmd.acc_init)
        begin
            idx_reg <= start8[MI_W-1:0];
            for (int c = 0; c < 3; c++)
                rec_reg[c] <= '0;
        end
        else if (cmd.acc_step)
        begin
            idx_reg <= idx_next;
            for (int c = 0; c < 3; c++)
                rec_reg[c] <= rec_next[c];
        end
        if (cmd.finish)
        begin
            mb_reg   <= moved[0];
            mg_reg   <= moved[1];
            mr_reg   <= moved[2];
            gray_reg <= gray_of_mask(moved);
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_rd_reg <= sum_mem[pos_reg];
            bgh_rd_reg <= bgh_mem[pos_reg];
            mvh_rd_reg <= mvh_mem[pos_reg];
        end
        if (cmd.clear_step)
            sum_mem[clr_reg] <= '0;
        else if (cmd.finish && sampled)
            sum_mem[pos_reg] <= {sum_new[2], sum_new[1], sum_new[0]};
        if (cmd.finish && sampled)
            bgh_mem[pos_reg] <= bgh_wr;
        if (cmd.finish)
            mvh_mem[pos_reg] <= mvh_wr;
    end

    always_comb
    begin
        status.clear_last = (32'(clr_reg) == PIXELS - 1);
        status.mod_last   = (step_reg == STEP_W'(MOD_STEPS - 1));
        status.acc_last   = (8'(k_reg) + 8'd1 == n8);
        status.div_last   = (step_reg == STEP_W'(NUM_W - 1));
    end

    assign moved_blue  = mb_reg;
    assign moved_green = mg_reg;
    assign moved_red   = mr_reg;
    assign gray_level  = gray_reg;

endmodule

// ===== hw/rtl/pixel_motion_mask_unit.sv =====
`timescale 1ns / 1ps

// pixel motion mask: takes bgr pixels in raster order (last_pixel marks the
// end of a frame) and flags, per channel, whether a linearly weighted average
// of the last move_window frames at that position differs from the mean of a
// background window (one frame in bg_skip, bg_window deep) by at least
// discard_level; gray_level is the rounded luma of the 0/254 channel mask.
// after an item is accepted, the block works it in this order, n being the
// frames in the recent window (1..MOVE_DEPTH): a 16 step remainder pass for
// the frame phase and ring heads, a prepare state, n steps of the weighted
// sum, a load of the quotient lanes, 24 steps (default depths) of the
// restoring quotient lanes and delivery of the result.
// the next item is accepted in the cycle after delivery at the earliest, so
// no new item is taken before the last one is delivered; a result still held
// in the output register delays the delivery of the next one. one item is
// worked at a time; a finished result waits in the output register while the
// next item is taken. after reset a clearing pass over all PIXELS positions
// zeroes the background sums before the first item is accepted; configuration
// writes are taken at any time but must only be made while the block is idle.
module pixel_motion_mask_unit
    import pmm_pkg::*;
#(
    parameter int PIXELS     = 4096,
    parameter int BG_DEPTH   = 16,
    parameter int MOVE_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    pmm_pix_if.sink    pix_in,
    pmm_mask_if.source mask_out
);

    // command and status between sequencer and datapath
    pmm_cmd_t    cmd;
    pmm_status_t status;

    // sequencer: clear pass, remainder, accumulate, divide, deliver
    pmm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (mask_out.valid),
        .out_ready (mask_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // per pixel memories, window bookkeeping and arithmetic
    pmm_datapath #(
        .PIXELS     (PIXELS),
        .BG_DEPTH   (BG_DEPTH),
        .MOVE_DEPTH (MOVE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .blue        (pix_in.blue),
        .green       (pix_in.green),
        .red         (pix_in.red),
        .last_pixel  (pix_in.last_pixel),
        .cmd         (cmd),
        .status      (status),
        .moved_blue  (mask_out.moved_blue),
        .moved_green (mask_out.moved_green),
        .moved_red   (mask_out.moved_red),
        .gray_level  (mask_out.gray_level)
    );

endmodule

// ===== tb/tb_pixel_motion_mask_unit.sv =====
`timescale 1ns / 1ps

module tb_pixel_motion_mask_unit;
    import pmm_pkg::*;

    localparam int PIXELS     = 4096;
    localparam int BG_DEPTH   = 16;
    localparam int MOVE_DEPTH = 8;
    // every frame has the same length, so each ring slot read has been written
    localparam int FRAME_LEN  = 12;
    // settle with margin after the last result before touching registers
    localparam int SETTLE     = 120;

    // rounded gray of a 0/254 mask, bit 0 blue, bit 1 green, bit 2 red
    localparam logic [7:0] MASK_GRAY [8] = '{8'd0, 8'd29, 8'd149, 8'd178,
                                            8'd76, 8'd105, 8'd225, 8'd254};

    typedef struct {
        logic       moved_blue;
        logic       moved_green;
        logic       moved_red;
        logic [7:0] gray_level;
    } mask_item_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    pmm_pix_if  pix_in ();
    pmm_mask_if mask_out ();

    pixel_motion_mask_unit #(
        .PIXELS     (PIXELS),
        .BG_DEPTH   (BG_DEPTH),
        .MOVE_DEPTH (MOVE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in.sink),
        .mask_out  (mask_out.source)
    );

    // shadow registers, raw as written
    logic [7:0] sh_bg_skip;
    logic [7:0] sh_discard;
    logic [4:0] sh_bg_window;
    logic [3:0] sh_move_window;

    // shadow of the block's frame state
    int unsigned frame_count;
    int unsigned pixel_pos;
    int unsigned bg_fill, bg_head, move_fill, move_head;
    logic [15:0] bg_sum [PIXELS*3];
    logic [23:0] bg_ring [PIXELS*BG_DEPTH];
    logic [23:0] move_ring [PIXELS*MOVE_DEPTH];

    mask_item_t masks_pending [$];
    int         errors;
    int         items_sent;
    int         results_seen;
    int         moved_seen;
    int         settings_seen;
    bit         calm;    // no idling on either side while set
    logic [7:0] base_b [FRAME_LEN];
    logic [7:0] base_g [FRAME_LEN];
    logic [7:0] base_r [FRAME_LEN];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_pixel_motion_mask_unit: errors");
        $finish;
    end

    function automatic int unsigned window_of(int unsigned w, int unsigned depth);
        if (w == 0)
            return 1;
        return (w > depth) ? depth : w;
    endfunction

    function automatic int unsigned clamp_q8(int unsigned q);
        return (q > 254 * 256) ? 255 * 256 : q;
    endfunction

    // expected mask of one pixel; advances the shadow frame state
    function automatic mask_item_t motion_of_pixel(logic [7:0] b, logic [7:0] g,
                                                   logic [7:0] r, logic last);
        mask_item_t  m;
        int unsigned skip, bw, mw, bh, mh, slot, bg_cnt, n, start, wsum;
        int unsigned rec [3];
        int unsigned pix [3];
        int unsigned rq, bq, d;
        logic [23:0] cur, old, e;
        logic [2:0]  mask;
        bit          sampled, bg_full, mv_full;

        skip    = (sh_bg_skip == 0) ? 1 : sh_bg_skip;
        bw      = window_of(sh_bg_window, BG_DEPTH);
        mw      = window_of(sh_move_window, MOVE_DEPTH);
        bh      = bg_head % bw;
        mh      = move_head % mw;
        sampled = (frame_count % skip) == 0;
        bg_full = bg_fill >= bw;
        mv_full = move_fill >= mw;
        pix[0]  = b;
        pix[1]  = g;
        pix[2]  = r;
        cur     = {r, g, b};
        mask    = '0;

        // background window with running sum (16 bit, wraps)
        if (sampled)
        begin
            slot = bg_full ? bh : (bh + bg_fill) % bw;
            old  = bg_full ? bg_ring[pixel_pos*BG_DEPTH + slot] : 24'd0;
            for (int c = 0; c < 3; c++)
                bg_sum[pixel_pos*3 + c] = bg_sum[pixel_pos*3 + c] + 16'(pix[c])
                                          - 16'(old[8*c +: 8]);
            bg_ring[pixel_pos*BG_DEPTH + slot] = cur;
            bg_cnt = bg_full ? bw : bg_fill + 1;
        end
        else
            bg_cnt = bg_full ? bw : bg_fill;

        // recent ring, weight 1 for oldest up to n for newest
        slot = mv_full ? mh : (mh + move_fill) % mw;
        move_ring[pixel_pos*MOVE_DEPTH + slot] = cur;
        n     = mv_full ? mw : move_fill + 1;
        start = mv_full ? (mh + 1) % mw : mh;
        wsum  = n * (n + 1) / 2;
        for (int c = 0; c < 3; c++)
            rec[c] = 0;
        for (int k = 0; k < n; k++)
        begin
            e = move_ring[pixel_pos*MOVE_DEPTH + (start + k) % mw];
            for (int c = 0; c < 3; c++)
                rec[c] += e[8*c +: 8] * (k + 1);
        end

        // no background yet leaves the mask clear
        if (bg_cnt != 0)
            for (int c = 0; c < 3; c++)
            begin
                rq = clamp_q8((rec[c] << 8) / wsum);
                bq = clamp_q8((int'(bg_sum[pixel_pos*3 + c]) << 8) / bg_cnt);
                d  = (rq > bq) ? rq - bq : bq - rq;
                mask[c] = (d != 0) && (d >= sh_discard * 256);
            end

        m.moved_blue  = mask[0];
        m.moved_green = mask[1];
        m.moved_red   = mask[2];
        m.gray_level  = MASK_GRAY[mask];

        if (last)
        begin
            pixel_pos = 0;
            if (sampled)
            begin
                if (bg_full)
                begin
                    bg_head = (bh + 1) % bw;
                    bg_fill = bw;
                end
                else
                begin
                    bg_head = bh;
                    bg_fill = bg_fill + 1;
                end
            end
            if (mv_full)
            begin
                move_head = (mh + 1) % mw;
                move_fill = mw;
            end
            else
            begin
                move_head = mh;
                move_fill = move_fill + 1;
            end
            frame_count = (frame_count + 1) & 16'hFFFF;
        end
        else
            pixel_pos = (pixel_pos + 1 >= PIXELS) ? 0 : pixel_pos + 1;
        return m;
    endfunction

    // one pixel item: random gap, hold until taken, then predict its mask
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
        int         gap;
        mask_item_t exp_m;
        gap = calm ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.blue       <= b;
        pix_in.green      <= g;
        pix_in.red        <= r;
        pix_in.last_pixel <= last;
        do
            @(posedge clk);
        while (!(pix_in.valid && pix_in.ready));
        exp_m = motion_of_pixel(b, g, r, last);
        masks_pending.insert(masks_pending.size(), exp_m);
        items_sent++;
    endtask

    // drop valid and let the block drain before touching registers
    task automatic wait_idle();
        @(negedge clk);
        pix_in.valid <= 1'b0;
        while (masks_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BG_SKIP:       sh_bg_skip     = val;
            CFG_DISCARD_LEVEL: sh_discard     = val;
            CFG_BG_WINDOW:     sh_bg_window   = val[4:0];
            default:           sh_move_window = val[3:0];
        endcase
    endtask

    task automatic apply_setting(logic [7:0] skip, logic [7:0] disc,
                                 logic [7:0] bgw, logic [7:0] mvw);
        wait_idle();
        write_reg(CFG_BG_SKIP, skip);
        write_reg(CFG_DISCARD_LEVEL, disc);
        write_reg(CFG_BG_WINDOW, bgw);
        write_reg(CFG_MOVE_WINDOW, mvw);
        settings_seen++;
    endtask

    // one frame: per position background plus noise, with random pixel jumps now and then
    task automatic send_frame(int jump_pct);
        logic [7:0] b, g, r;
        for (int p = 0; p < FRAME_LEN; p++)
        begin
            if ($urandom_range(0, 99) < jump_pct)
            begin
                b = $urandom;
                g = $urandom;
                r = $urandom;
            end
            else
            begin
                b = base_b[p] ^ 8'($urandom_range(0, 7));
                g = base_g[p] ^ 8'($urandom_range(0, 7));
                r = base_r[p] ^ 8'($urandom_range(0, 7));
            end
            send_pixel(b, g, r, p == FRAME_LEN - 1);
        end
    endtask

    task automatic new_background();
        for (int p = 0; p < FRAME_LEN; p++)
        begin
            base_b[p] = $urandom;
            base_g[p] = $urandom;
            base_r[p] = $urandom;
        end
    endtask

    // mask result checker, receiver stalls drawn per item
    initial
    begin
        int         stall;
        mask_item_t exp_m;
        mask_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (stall > 0)
            begin
                mask_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            mask_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(mask_out.valid && mask_out.ready));
            results_seen++;
            if (masks_pending.size() == 0)
            begin
                $error("mask item with no pixel waiting for it");
                errors++;
            end
            else
            begin
                exp_m = masks_pending.pop_front();
                if (mask_out.moved_blue !== exp_m.moved_blue)
                begin
                    $error("moved_blue: expected %0d, got %0d",
                           exp_m.moved_blue, mask_out.moved_blue);
                    errors++;
                end
                if (mask_out.moved_green !== exp_m.moved_green)
                begin
                    $error("moved_green: expected %0d, got %0d",
                           exp_m.moved_green, mask_out.moved_green);
                    errors++;
                end
                if (mask_out.moved_red !== exp_m.moved_red)
                begin
                    $error("moved_red: expected %0d, got %0d",
                           exp_m.moved_red, mask_out.moved_red);
                    errors++;
                end
                if (mask_out.gray_level !== exp_m.gray_level)
                begin
                    $error("gray_level: expected %0d, got %0d",
                           exp_m.gray_level, mask_out.gray_level);
                    errors++;
                end
                if (exp_m.gray_level != 0)
                    moved_seen++;
            end
        end
    end

    // extremes of every channel, both last_pixel values, first frame has no
    // history so mask stays clear until background forms
    task automatic test_directed();
        logic [7:0] v [FRAME_LEN];
        v = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127,
              8'd0, 8'd255, 8'd85, 8'd170, 8'd15, 8'd240};
        for (int p = 0; p < FRAME_LEN; p++)
            send_pixel(v[p], v[FRAME_LEN - 1 - p], ~v[p], p == FRAME_LEN - 1);
        // second frame flips channels per position to vary the mask per position
        for (int p = 0; p < FRAME_LEN; p++)
            send_pixel(p[0] ? ~v[p] : v[p],
                       p[1] ? ~v[FRAME_LEN - 1 - p] : v[FRAME_LEN - 1 - p],
                       p[2] ? v[p] : ~v[p], p == FRAME_LEN - 1);
    endtask

    // register sweep with extremes; zero and oversized windows and skip zero
    task automatic test_config_sweep();
        logic [7:0] plan [10][4];
        plan = '{'{8'd1,   8'd0,   8'd1,  8'd1},
                 '{8'd0,   8'd255, 8'd16, 8'd8},
                 '{8'd255, 8'd1,   8'd0,  8'd0},
                 '{8'd2,   8'd10,  8'd31, 8'd15},
                 '{8'd3,   8'd30,  8'd5,  8'd3},
                 '{8'd1,   8'd128, 8'd16, 8'd8},
                 '{8'd1,   8'd4,   8'd2,  8'd7},
                 '{8'd7,   8'd0,   8'd9,  8'd4},
                 '{8'd1,   8'd20,  8'd16, 8'd1},
                 '{8'd1,   8'd30,  8'd16, 8'd8}};
        for (int s = 0; s < 10; s++)
        begin
            apply_setting(plan[s][0], plan[s][1], plan[s][2], plan[s][3]);
            new_background();
            repeat (3) send_frame(30);
        end
    endtask

    // long stream of well-formed frames, steady scenes with motion bursts
    task automatic test_random_frames();
        for (int f = 0; f < 120; f++)
        begin
            if (f % 30 == 0 && f != 0)
                apply_setting(8'($urandom_range(1, 3)), 8'($urandom_range(0, 60)),
                              8'($urandom_range(1, 16)), 8'($urandom_range(1, 8)));
            if ($urandom_range(0, 9) == 0)
                new_background();
            calm = ($urandom_range(0, 5) == 0);
            send_frame($urandom_range(0, 3) == 0 ? 60 : 5);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        moved_seen    = 0;
        settings_seen = 0;
        calm          = 1'b0;
        sh_bg_skip     = 8'd1;
        sh_discard     = 8'd30;
        sh_bg_window   = 5'd16;
        sh_move_window = 4'd8;
        frame_count = 0;
        pixel_pos   = 0;
        bg_fill     = 0;
        bg_head     = 0;
        move_fill   = 0;
        move_head   = 0;
        foreach (bg_sum[i])
            bg_sum[i] = '0;
        foreach (bg_ring[i])
            bg_ring[i] = '0;
        foreach (move_ring[i])
            move_ring[i] = '0;
        new_background();

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_BG_SKIP;
        cfg_data          = '0;
        pix_in.valid      = 1'b0;
        pix_in.blue       = '0;
        pix_in.green      = '0;
        pix_in.red        = '0;
        pix_in.last_pixel = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clearing pass after reset is covered by the handshake wait
        test_directed();
        test_config_sweep();
        test_random_frames();
        wait_idle();

        $display("covered %0d pixels in %0d-pixel frames, %0d results, %0d with motion",
                 items_sent, FRAME_LEN, results_seen, moved_seen);
        $display("register settings applied: %0d, frames seen: %0d",
                 settings_seen, frame_count);
        if (errors == 0)
            $display("tb_pixel_motion_mask_unit: clean");
        else
            $display("tb_pixel_motion_mask_unit: errors");
        $finish;
    end

endmodule
